// ===== hw/rtl/cdq_pkg.sv =====
// Shared types and constants for the circular deque unit.
package cdq_pkg;

   localparam int DEPTH   = 128;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;
   localparam int COUNT_W = 8;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5,
      OP_CLEAR      = 3'd6,
      OP_REVERSE    = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Per-cell control: take the left neighbor, take the right neighbor, or load.
   typedef struct packed {
      logic shift_in;
      logic shift_out;
      logic load;
   } cell_ctl_type;

   // Command for one row of cells.
   typedef struct packed {
      logic             push_head;
      logic             pop_head;
      logic             wr_tail;
      logic [IDX_W-1:0] tail_idx;
   } chain_cmd_type;

endpackage

// ===== hw/rtl/cdq_cell.sv =====
// One storage cell of a deque row: holds a word and trades it with its neighbors.
module cdq_cell
   import cdq_pkg::*;
(
   input  logic                clock,
   input  cell_ctl_type        ctl,
   input  logic [WORD_W-1:0]   left_data,
   input  logic [WORD_W-1:0]   right_data,
   input  logic [WORD_W-1:0]   load_data,
   output logic [WORD_W-1:0]   q
);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      priority if (ctl.shift_in) begin
         word_in = left_data;
      end else if (ctl.shift_out) begin
         word_in = right_data;
      end else if (ctl.load) begin
         word_in = load_data;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign q = word_ff;

endmodule

// ===== hw/rtl/cdq_chain.sv =====
// Row of deque cells with the head word at cell zero.
module cdq_chain
   import cdq_pkg::*;
(
   input  logic                clock,
   input  chain_cmd_type       cmd,
   input  logic [WORD_W-1:0]   value,
   output logic [WORD_W-1:0]   head_q
);

   logic [WORD_W-1:0] cell_q [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctl_type      ctl;
      logic [WORD_W-1:0] left_data;
      logic [WORD_W-1:0] right_data;

      assign ctl.shift_in  = cmd.push_head;
      assign ctl.shift_out = cmd.pop_head;
      // Write at the tail only in the cell whose position matches.
      assign ctl.load      = cmd.wr_tail && (cmd.tail_idx == IDX_W'(i));

      if (i == 0) begin : g_first
         assign left_data = value;
      end else begin : g_inner_left
         assign left_data = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = cell_q[i];
      end else begin : g_inner_right
         assign right_data = cell_q[i+1];
      end

      cdq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .left_data  (left_data),
         .right_data (right_data),
         .load_data  (value),
         .q          (cell_q[i])
      );
   end

   assign head_q = cell_q[0];

endmodule

// ===== hw/rtl/circular_deque_unit.sv =====
// Circular deque unit: double-ended queue of signed words with status reporting.
//
// Usage: drive req_opcode and req_value with start high; a request is taken
// at a rising edge where start is high and busy is low. busy stays low, so a
// new request may be issued every cycle: one request per clock, sustained.
// Each request gives exactly one response, on the rsp_ ports for one cycle
// with rsp_valid high, in the cycle right after the request is taken.
// The receiver cannot hold responses off; a response is gone after its cycle.
// Storage is two rows of cells holding the same words in opposite orders,
// one with the front word at cell zero and one with the back word at cell
// zero. A push at an end shifts the row that owns that end and writes the
// other row at the position given by the count; a pop shifts the owning row.
// Both ends are therefore read at fixed cells. Reverse swaps row ownership.
// Reset (synchronous, active high) empties the deque, clears the orientation
// and drops any pending response; stored words need no clearing.
module circular_deque_unit
   import cdq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_opcode,
   input  logic signed [WORD_W-1:0]   req_value,
   output logic                       rsp_valid,
   output logic signed [WORD_W-1:0]   rsp_data,
   output logic [1:0]                 rsp_status,
   output logic [COUNT_W-1:0]         rsp_count,
   output logic                       rsp_is_empty,
   output logic                       rsp_is_full
);

   logic [CNT_W-1:0]  occ_ff;
   logic [CNT_W-1:0]  occ_in;
   logic              rev_ff;
   logic              rev_in;
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_data_ff;
   logic [WORD_W-1:0] rsp_data_in;
   status_type        rsp_status_ff;
   status_type        rsp_status_in;
   logic [CNT_W-1:0]  rsp_occ_ff;

   chain_cmd_type     cmd_a;
   chain_cmd_type     cmd_b;
   logic [WORD_W-1:0] head_a;
   logic [WORD_W-1:0] head_b;

   logic              accept;
   logic              empty;
   logic              full;
   logic              at_a;
   op_type            op;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign op     = op_type'(req_opcode);
   assign empty  = (occ_ff == '0);
   assign full   = (occ_ff == FULL_COUNT);

   // Row A owns the front unless reversed.
   always_comb begin
      unique case (op)
         OP_PUSH_FRONT, OP_POP_FRONT, OP_PEEK_FRONT: at_a = !rev_ff;
         default:                                    at_a = rev_ff;
      endcase
   end

   always_comb begin
      cmd_a          = '0;
      cmd_b          = '0;
      cmd_a.tail_idx = occ_ff[IDX_W-1:0];
      cmd_b.tail_idx = occ_ff[IDX_W-1:0];
      occ_in         = occ_ff;
      rev_in         = rev_ff;
      rsp_data_in    = '0;
      rsp_status_in  = ST_OK;
      if (accept) begin
         unique case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  cmd_a.push_head = at_a;
                  cmd_b.wr_tail   = at_a;
                  cmd_b.push_head = !at_a;
                  cmd_a.wr_tail   = !at_a;
                  occ_in          = occ_ff + 1'b1;
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_data_in    = at_a ? head_a : head_b;
                  cmd_a.pop_head = at_a;
                  cmd_b.pop_head = !at_a;
                  occ_in         = occ_ff - 1'b1;
               end
            end
            OP_PEEK_FRONT, OP_PEEK_BACK: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_data_in = at_a ? head_a : head_b;
               end
            end
            OP_CLEAR: begin
               occ_in = '0;
               rev_in = 1'b0;
            end
            OP_REVERSE: begin
               rev_in = !rev_ff;
            end
         endcase
      end
   end

   cdq_chain u_row_a (
      .clock  (clock),
      .cmd    (cmd_a),
      .value  (req_value),
      .head_q (head_a)
   );

   cdq_chain u_row_b (
      .clock  (clock),
      .cmd    (cmd_b),
      .value  (req_value),
      .head_q (head_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= occ_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = COUNT_W'(rsp_occ_ff);
   assign rsp_is_empty = (rsp_occ_ff == '0);
   assign rsp_is_full  = (rsp_occ_ff == FULL_COUNT);

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_COUNT)
      else $error("occupancy beyond depth");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("request without response");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> rsp_is_full)
      else $error("full status on a deque that is not full");

   a_empty_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_is_empty && rsp_data == '0))
      else $error("empty status with data or entries");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the circular deque unit: directed table, then random requests.
module tb_top
   import cdq_pkg::*;
();

   typedef struct packed {
      logic [WORD_W-1:0]  data;
      logic [1:0]         status;
      logic [COUNT_W-1:0] count;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

   typedef struct packed {
      op_type            op;
      logic [WORD_W-1:0] value;
      logic [7:0]        reps;
      logic              known;
      rsp_type           rsp;
   } row_type;

   typedef enum logic [1:0] {
      BURST_FILL,
      BURST_DRAIN,
      BURST_MIX
   } burst_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [2:0]               req_opcode = OP_PUSH_FRONT;
   logic signed [WORD_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic signed [WORD_W-1:0] rsp_data;
   logic [1:0]               rsp_status;
   logic [COUNT_W-1:0]       rsp_count;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;

   // Shadow copy of the deque contents and pointers.
   logic [WORD_W-1:0] dq_words [DEPTH];
   int                dq_head = 0;
   int                dq_tail = 0;
   int                dq_held = 0;
   logic              dq_flipped = 1'b0;

   rsp_type pending_rsps [$];
   row_type directed_rows [$];
   int      fail_count = 0;
   int      idle_pct = 0;

   circular_deque_unit i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count),
      .rsp_is_empty(rsp_is_empty),
      .rsp_is_full(rsp_is_full)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int wrap_up(int i);
      return (i == DEPTH - 1) ? 0 : i + 1;
   endfunction

   function automatic int wrap_down(int i);
      return (i == 0) ? DEPTH - 1 : i - 1;
   endfunction

   // Apply one request to the shadow deque and return the response it must give.
   function automatic rsp_type deque_apply(op_type op, logic [WORD_W-1:0] value);
      rsp_type r;
      logic    at_head;
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            // front sits at the storage head unless flipped
            at_head = (op == OP_PUSH_FRONT) ^ dq_flipped;
            if (dq_held == DEPTH) begin
               r.status = ST_FULL;
            end else begin
               if (dq_held == 0) begin
                  dq_head = 0;
                  dq_tail = 0;
               end else if (at_head) begin
                  dq_head = wrap_down(dq_head);
               end else begin
                  dq_tail = wrap_up(dq_tail);
               end
               dq_words[at_head ? dq_head : dq_tail] = value;
               dq_held++;
            end
         end
         OP_CLEAR: begin
            dq_head = 0;
            dq_tail = 0;
            dq_held = 0;
            dq_flipped = 1'b0;
         end
         OP_REVERSE: dq_flipped = ~dq_flipped;
         default: begin
            at_head = (op == OP_POP_FRONT || op == OP_PEEK_FRONT) ^ dq_flipped;
            if (dq_held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.data = dq_words[at_head ? dq_head : dq_tail];
               if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
                  // hold the pointers when the last word leaves
                  if (dq_held > 1) begin
                     if (at_head) dq_head = wrap_up(dq_head);
                     else dq_tail = wrap_down(dq_tail);
                  end
                  dq_held--;
               end
            end
         end
      endcase
      r.count = COUNT_W'(dq_held);
      r.is_empty = (dq_held == 0);
      r.is_full = (dq_held == DEPTH);
      return r;
   endfunction

   function automatic void plan(op_type op, logic [WORD_W-1:0] value, int reps = 1);
      row_type row;
      row = '0;
      row.op = op;
      row.value = value;
      row.reps = 8'(reps);
      directed_rows = {directed_rows, row};
   endfunction

   function automatic void plan_known(op_type op, logic [WORD_W-1:0] value,
                                      logic [WORD_W-1:0] data, status_type status,
                                      int count, logic is_empty, logic is_full);
      row_type row;
      row = '0;
      row.op = op;
      row.value = value;
      row.reps = 8'd1;
      row.known = 1'b1;
      row.rsp.data = data;
      row.rsp.status = status;
      row.rsp.count = COUNT_W'(count);
      row.rsp.is_empty = is_empty;
      row.rsp.is_full = is_full;
      directed_rows = {directed_rows, row};
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic op_type random_op(burst_type burst);
      int roll;
      int pick;
      roll = $urandom_range(99);
      pick = $urandom_range(6);
      case (burst)
         BURST_FILL: begin
            if (roll < 85) return pick[0] ? OP_PUSH_BACK : OP_PUSH_FRONT;
         end
         BURST_DRAIN: begin
            if (roll < 85) begin
               if (pick == 4) return OP_PEEK_FRONT;
               if (pick == 5) return OP_PEEK_BACK;
               return pick[0] ? OP_POP_BACK : OP_POP_FRONT;
            end
         end
         default: begin
            if (roll < 2) return OP_CLEAR;
         end
      endcase
      // anything but clear
      return (pick == 6) ? OP_REVERSE : op_type'(pick);
   endfunction

   function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                       logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Called at a rising edge; returns at the edge where the request is taken.
   task automatic issue(input op_type op, input logic [WORD_W-1:0] value,
                        input logic known, input rsp_type typed);
      rsp_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = deque_apply(op, value);
      pending_rsps = {pending_rsps, (known ? typed : predicted)};
   endtask

   task automatic drain_pending();
      start <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   // Random requests in bursts that fill, drain or mix, so the deque swings
   // between empty and full many times.
   task automatic run_phase(int items);
      burst_type burst;
      int        burst_len;
      burst_len = 0;
      burst = BURST_MIX;
      for (int n = 0; n < items; n++) begin
         if (burst_len == 0) begin
            burst = burst_type'($urandom_range(2));
            burst_len = (burst == BURST_MIX) ? $urandom_range(10, 60)
                                             : $urandom_range(20, 150);
         end
         burst_len--;
         issue(random_op(burst), random_word(), 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      rsp_type expected;
      if (!reset && rsp_valid) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t: response with no request pending: expected none, actual data %0h",
                     $time, rsp_data);
            fail_count++;
         end else begin
            expected = pending_rsps[0];
            pending_rsps.delete(0);
            check_field("data", expected.data, rsp_data);
            check_field("status", expected.status, rsp_status);
            check_field("count", expected.count, rsp_count);
            check_field("is_empty", expected.is_empty, rsp_is_empty);
            check_field("is_full", expected.is_full, rsp_is_full);
         end
      end
   end

   initial begin
      plan_known(OP_PEEK_FRONT, 32'h0, 32'h0, ST_EMPTY, 0, 1'b1, 1'b0);
      plan_known(OP_POP_BACK, 32'hFFFF_FFFF, 32'h0, ST_EMPTY, 0, 1'b1, 1'b0);
      plan_known(OP_PUSH_BACK, 32'h7FFF_FFFF, 32'h0, ST_OK, 1, 1'b0, 1'b0);
      plan_known(OP_PUSH_FRONT, 32'h8000_0000, 32'h0, ST_OK, 2, 1'b0, 1'b0);
      plan_known(OP_PEEK_FRONT, 32'h0, 32'h8000_0000, ST_OK, 2, 1'b0, 1'b0);
      plan_known(OP_PEEK_BACK, 32'hFFFF_FFFF, 32'h7FFF_FFFF, ST_OK, 2, 1'b0, 1'b0);
      plan_known(OP_REVERSE, 32'h0, 32'h0, ST_OK, 2, 1'b0, 1'b0);
      plan_known(OP_PEEK_FRONT, 32'h0, 32'h7FFF_FFFF, ST_OK, 2, 1'b0, 1'b0);
      plan(OP_PUSH_FRONT, 32'hFFFF_FFFF);
      plan(OP_POP_BACK, 32'h0);
      plan(OP_POP_FRONT, 32'hFFFF_FFFF);
      // pop the last word while reversed
      plan(OP_POP_FRONT, 32'h0);
      plan_known(OP_POP_FRONT, 32'h0, 32'h0, ST_EMPTY, 0, 1'b1, 1'b0);
      plan_known(OP_REVERSE, 32'h0, 32'h0, ST_OK, 0, 1'b1, 1'b0);
      plan(OP_PUSH_BACK, 32'h0);
      plan(OP_REVERSE, 32'hFFFF_FFFF);
      plan(OP_PEEK_BACK, 32'h0);
      plan(OP_PUSH_FRONT, 32'h5A5A_0000, DEPTH - 1);
      plan_known(OP_PUSH_BACK, 32'h1234_5678, 32'h0, ST_FULL, DEPTH, 1'b0, 1'b1);
      plan_known(OP_PUSH_FRONT, 32'h0, 32'h0, ST_FULL, DEPTH, 1'b0, 1'b1);
      plan(OP_PEEK_BACK, 32'h0);
      plan(OP_REVERSE, 32'h0);
      plan(OP_POP_FRONT, 32'h0);
      plan_known(OP_CLEAR, 32'hFFFF_FFFF, 32'h0, ST_OK, 0, 1'b1, 1'b0);
      plan_known(OP_PEEK_BACK, 32'h0, 32'h0, ST_EMPTY, 0, 1'b1, 1'b0);
      plan_known(OP_PUSH_FRONT, 32'h1, 32'h0, ST_OK, 1, 1'b0, 1'b0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         for (int k = 0; k < directed_rows[i].reps; k++) begin
            issue(directed_rows[i].op, directed_rows[i].value + k,
                  directed_rows[i].known, directed_rows[i].rsp);
         end
      end
      drain_pending();

      idle_pct = 8;
      run_phase(300);
      drain_pending();
      idle_pct = 76;
      run_phase(300);
      drain_pending();
      idle_pct = 0;
      run_phase(300);
      drain_pending();

      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
